### hdl/cpma_pkg.sv
// Package for the centered point moving average unit.
// Holds the point and result transaction structs and the fixed field widths.
// No dependencies.
package cpma_pkg;

    localparam int COORD_W   = 12;   // input coordinate, whole pixels
    localparam int OUT_W     = 16;   // output coordinate, 1/16 pixel
    localparam int FRAC_BITS = 4;

    typedef struct packed {
        logic [COORD_W-1:0] x_in;
        logic [COORD_W-1:0] y_in;
        logic               is_last;
    } point_t;

    typedef struct packed {
        logic [OUT_W-1:0] x_out;
        logic [OUT_W-1:0] y_out;
        logic             last_out;
    } smooth_t;

endpackage

### hdl/centered_point_moving_average_unit.sv
// Centered moving average over a stream of polyline points.
// A transaction that completes a window sets the pending-result registers, which load the
// output register; results lag input by HALF_WINDOW points. Throughput: one point per cycle
// unless smooth_stall holds; a point marked is_last emits up to HALF_WINDOW+1 results, one per
// cycle unless stalled, from the single output register; input stalls until the last is issued.
// Reset (rst_n, async, active low) empties the window, the path count and the output.
module centered_point_moving_average_unit #(
    parameter int unsigned HALF_WINDOW = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_stall,
    input  cpma_pkg::point_t  point,
    output logic              smooth_valid,
    input  logic              smooth_stall,
    output cpma_pkg::smooth_t smooth
);

    localparam int COORD_W   = cpma_pkg::COORD_W;
    localparam int OUT_W     = cpma_pkg::OUT_W;
    localparam int FRAC_BITS = cpma_pkg::FRAC_BITS;

    localparam int WIN_LEN   = 2 * HALF_WINDOW + 1;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int SUM_W     = $clog2(WIN_LEN * COORD_MAX + 1);
    localparam int NUM_W     = $clog2(WIN_LEN * COORD_MAX * (1 << FRAC_BITS) + HALF_WINDOW + 1);
    localparam int PTS_W     = $clog2(WIN_LEN + 1);
    localparam int FL_W      = $clog2(HALF_WINDOW + 1);
    localparam int IDX_W     = $clog2(WIN_LEN);
    // reciprocal of the window length, rounded up; exact for all numerators below 2**NUM_W
    localparam int DIV_SHIFT = NUM_W + $clog2(WIN_LEN);
    localparam int PROD_W    = NUM_W + DIV_SHIFT + 1;
    localparam logic [DIV_SHIFT:0] RECIP =
        (DIV_SHIFT + 1)'(((64'd1 << DIV_SHIFT) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN));

    // window, newest at index 0, and running sums of its contents
    logic [COORD_W-1:0] xw_reg [WIN_LEN];
    logic [COORD_W-1:0] yw_reg [WIN_LEN];
    logic [SUM_W-1:0]   xsum_reg, xsum_next;
    logic [SUM_W-1:0]   ysum_reg, ysum_next;
    logic [PTS_W-1:0]   pts_reg, pts_next, pts_inc;

    // pending results of the latest transaction
    logic               head_reg, head_next;        // average or pass-through pending
    logic               head_avg_reg, head_avg_next;
    logic [FL_W-1:0]    flush_reg, flush_next;      // trailing points still to flush

    logic               out_valid_reg;
    cpma_pkg::smooth_t  out_reg;

    logic               accept;
    logic               job_busy;
    logic               out_free;
    logic               gen_fire;
    logic               gen_final;
    cpma_pkg::smooth_t  gen;
    logic [IDX_W-1:0]   flush_idx;
    logic [NUM_W-1:0]   xnum, ynum;
    logic [PROD_W-1:0]  xprod, yprod;
    logic               new_avg, new_pass;
    logic [FL_W-1:0]    held;

    assign job_busy  = head_reg || (flush_reg != '0);
    assign out_free  = !out_valid_reg || !smooth_stall;
    assign gen_fire  = job_busy && out_free;
    assign gen_final = head_reg ? (flush_reg == '0) : (flush_reg == FL_W'(1));
    assign point_stall = job_busy && !(gen_fire && gen_final);
    assign accept    = point_valid && !point_stall;

    assign smooth_valid = out_valid_reg;
    assign smooth       = out_reg;

    // rounded average: (sum*16 + HALF_WINDOW) / WIN_LEN via reciprocal multiply
    assign xnum  = NUM_W'({xsum_reg, {FRAC_BITS{1'b0}}}) + NUM_W'(HALF_WINDOW);
    assign ynum  = NUM_W'({ysum_reg, {FRAC_BITS{1'b0}}}) + NUM_W'(HALF_WINDOW);
    assign xprod = PROD_W'(xnum) * PROD_W'(RECIP);
    assign yprod = PROD_W'(ynum) * PROD_W'(RECIP);

    assign flush_idx = IDX_W'(flush_reg) - IDX_W'(1);

    always_comb
    begin
        if (head_reg)
        begin
            if (head_avg_reg)
            begin
                gen.x_out = xprod[DIV_SHIFT +: OUT_W];
                gen.y_out = yprod[DIV_SHIFT +: OUT_W];
            end
            else
            begin
                gen.x_out = {xw_reg[HALF_WINDOW], {FRAC_BITS{1'b0}}};
                gen.y_out = {yw_reg[HALF_WINDOW], {FRAC_BITS{1'b0}}};
            end
            gen.last_out = 1'b0;
        end
        else
        begin
            gen.x_out    = {xw_reg[flush_idx], {FRAC_BITS{1'b0}}};
            gen.y_out    = {yw_reg[flush_idx], {FRAC_BITS{1'b0}}};
            gen.last_out = (flush_reg == FL_W'(1));
        end
    end

    always_comb
    begin
        pts_inc  = (pts_reg < PTS_W'(WIN_LEN)) ? pts_reg + PTS_W'(1) : pts_reg;
        new_avg  = (pts_inc >= PTS_W'(WIN_LEN));
        new_pass = (pts_inc >= PTS_W'(HALF_WINDOW + 1));
        held     = (pts_inc < PTS_W'(HALF_WINDOW)) ? FL_W'(pts_inc) : FL_W'(HALF_WINDOW);

        xsum_next     = xsum_reg + SUM_W'(point.x_in) - SUM_W'(xw_reg[WIN_LEN-1]);
        ysum_next     = ysum_reg + SUM_W'(point.y_in) - SUM_W'(yw_reg[WIN_LEN-1]);
        pts_next      = pts_reg;
        head_next     = head_reg;
        head_avg_next = head_avg_reg;
        flush_next    = flush_reg;

        if (gen_fire)
        begin
            if (head_reg)
                head_next = 1'b0;
            else
                flush_next = flush_reg - FL_W'(1);
        end

        if (accept)
        begin
            pts_next      = point.is_last ? '0 : pts_inc;
            head_next     = new_pass;
            head_avg_next = new_avg;
            flush_next    = point.is_last ? held : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                xw_reg[i] <= '0;
                yw_reg[i] <= '0;
            end
            xsum_reg     <= '0;
            ysum_reg     <= '0;
            pts_reg      <= '0;
            head_reg     <= 1'b0;
            head_avg_reg <= 1'b0;
            flush_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = WIN_LEN - 1; i > 0; i--)
                begin
                    xw_reg[i] <= xw_reg[i-1];
                    yw_reg[i] <= yw_reg[i-1];
                end
                xw_reg[0] <= point.x_in;
                yw_reg[0] <= point.y_in;
                xsum_reg  <= xsum_next;
                ysum_reg  <= ysum_next;
            end
            pts_reg      <= pts_next;
            head_reg     <= head_next;
            head_avg_reg <= head_avg_next;
            flush_reg    <= flush_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (gen_fire)
            out_valid_reg <= 1'b1;
        else if (!smooth_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
            out_reg <= gen;
    end

    // a new transaction may only land when the previous one issues its final result
    a_accept_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        accept && job_busy |-> gen_fire && gen_final)
        else $error("point accepted while earlier results pending");

    // the path count restarts after a final point
    a_path_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && point.is_last |=> pts_reg == '0)
        else $error("path count not cleared after final point");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pts_reg <= PTS_W'(WIN_LEN) && flush_reg <= FL_W'(HALF_WINDOW))
        else $error("path or flush count out of range");

    // a marked result ends the pending work
    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        gen_fire && gen.last_out |=> !head_reg && flush_reg == '0 || $past(accept))
        else $error("results pending after last_out");

endmodule
